// ===== rtl/six_axis_biquad_lowpass_defines.svh =====
// ---------------------------------------------------------------------------
// Six-axis biquad low-pass: assertion macros
// Shared property wrappers for the concurrent checks in the top level.
// ---------------------------------------------------------------------------
`ifndef SIX_AXIS_BIQUAD_LOWPASS_DEFINES_SVH
`define SIX_AXIS_BIQUAD_LOWPASS_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SABQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SABQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sabq_pkg.sv =====
// ---------------------------------------------------------------------------
// Six-axis biquad low-pass: shared package
// Widths, beat types, coefficient tables and rounding helpers.
// ---------------------------------------------------------------------------
package sabq_pkg;

  localparam int AXES        = 3;
  localparam int LANES       = 2 * AXES;
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 8;
  localparam int COEF_W      = 16;
  localparam int COEF_FRAC   = 14;

  localparam int PROD_W = SAMPLE_BITS + COEF_W;
  localparam int FF_W   = PROD_W + 2;
  localparam int Y_W    = SAMPLE_BITS + FRAC_BITS;
  localparam int FB_W   = COEF_W + Y_W;
  localparam int ACC_W  = FF_W + FRAC_BITS + 1;
  localparam int SHR_W  = ACC_W - COEF_FRAC;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // Register indexes
  localparam logic REG_ACCEL_SEL = 1'b0;
  localparam logic REG_GYRO_SEL  = 1'b1;

  // Cutoff codes
  localparam logic [2:0] ACCEL_50HZ = 3'd0;
  localparam logic [2:0] ACCEL_25HZ = 3'd1;
  localparam logic [2:0] ACCEL_15HZ = 3'd2;
  localparam logic [2:0] ACCEL_10HZ = 3'd3;
  localparam logic [1:0] GYRO_100HZ = 2'd0;
  localparam logic [1:0] GYRO_50HZ  = 2'd1;

  localparam logic [2:0] ACCEL_SEL_RESET = ACCEL_25HZ;
  localparam logic [1:0] GYRO_SEL_RESET  = GYRO_100HZ;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]      coefv_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [FF_W-1:0]        ff_t;
  typedef logic signed [Y_W-1:0]         yval_t;
  typedef logic signed [FB_W-1:0]        fb_t;
  typedef logic signed [ACC_W-1:0]       acc_t;

  typedef struct packed {
    coefv_t b0;
    coefv_t b1;
    coefv_t b2;
    coefv_t a1;
    coefv_t a2;
  } coef_t;

  typedef struct packed {
    logic load;  // sample beat accepted: take products, shift input history
    logic adv;   // products move to the feedforward sum
    logic fire;  // feedback step: new output enters the output history
  } lane_ctrl_t;

  typedef struct packed {
    sample_t gyro_x;
    sample_t gyro_y;
    sample_t gyro_z;
    sample_t accel_x;
    sample_t accel_y;
    sample_t accel_z;
  } sabq_in_t;

  typedef struct packed {
    sample_t gyro_x_filtered;
    sample_t gyro_y_filtered;
    sample_t gyro_z_filtered;
    sample_t accel_x_filtered;
    sample_t accel_y_filtered;
    sample_t accel_z_filtered;
  } sabq_out_t;

  function automatic coef_t make_coef(int b0, int b1, int b2, int a1, int a2);
    coef_t c;
    c.b0 = COEF_W'(b0);
    c.b1 = COEF_W'(b1);
    c.b2 = COEF_W'(b2);
    c.a1 = COEF_W'(a1);
    c.a2 = COEF_W'(a2);
    return c;
  endfunction

  // Codes above the 5 Hz set fall back to it.
  function automatic coef_t accel_coef(logic [2:0] sel);
    coef_t c;
    unique case (sel)
      ACCEL_50HZ: c = make_coef(1478, 2956, 1478, 16211, 5739);
      ACCEL_25HZ: c = make_coef(480, 960, 480, 23936, 9471);
      ACCEL_15HZ: c = make_coef(193, 385, 193, 27373, 11759);
      ACCEL_10HZ: c = make_coef(90, 181, 90, 29148, 13126);
      default:    c = make_coef(24, 48, 24, 30951, 14663);
    endcase
    return c;
  endfunction

  // Code 3 falls back to the 25 Hz set.
  function automatic coef_t gyro_coef(logic [1:0] sel);
    coef_t c;
    unique case (sel)
      GYRO_100HZ: c = make_coef(3705, 7411, 3705, 4603, 3040);
      GYRO_50HZ:  c = make_coef(1478, 2956, 1478, 16211, 5739);
      default:    c = make_coef(480, 960, 480, 23936, 9471);
    endcase
    return c;
  endfunction

  // Q22 sum to Q8 state: round half up, floor shift, saturate.
  function automatic yval_t y_round_sat(acc_t a);
    acc_t                   r;
    logic [SHR_W-1:0]       s;
    r = a + ACC_W'(1 << (COEF_FRAC - 1));
    s = r[ACC_W-1:COEF_FRAC];
    if ((&s[SHR_W-1:Y_W-1]) || (~|s[SHR_W-1:Y_W-1])) begin
      return yval_t'(s[Y_W-1:0]);
    end else if (s[SHR_W-1]) begin
      return yval_t'({1'b1, {(Y_W-1){1'b0}}});
    end else begin
      return yval_t'({1'b0, {(Y_W-1){1'b1}}});
    end
  endfunction

  // Q8 state to integer output: round half up, floor shift, saturate.
  function automatic sample_t out_round_sat(yval_t y);
    logic signed [Y_W:0]      r;
    logic [Y_W-FRAC_BITS:0]   s;
    r = {y[Y_W-1], y} + (Y_W+1)'(1 << (FRAC_BITS - 1));
    s = r[Y_W:FRAC_BITS];
    if ((&s[Y_W-FRAC_BITS:SAMPLE_BITS-1]) || (~|s[Y_W-FRAC_BITS:SAMPLE_BITS-1])) begin
      return sample_t'(s[SAMPLE_BITS-1:0]);
    end else if (s[Y_W-FRAC_BITS]) begin
      return sample_t'({1'b1, {(SAMPLE_BITS-1){1'b0}}});
    end else begin
      return sample_t'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    end
  endfunction

endpackage

// ===== rtl/sabq_lane.sv =====
// ---------------------------------------------------------------------------
// Biquad lane
// One direct form I second-order section: registered feedforward products,
// feedforward sum, then a combinational feedback step into the history.
// ---------------------------------------------------------------------------
module sabq_lane (
  input  logic                 clk,
  input  logic                 rst,
  input  sabq_pkg::lane_ctrl_t ctrl,
  input  sabq_pkg::coef_t      coef,
  input  sabq_pkg::sample_t    x,
  output sabq_pkg::yval_t      y
);
  import sabq_pkg::*;

  sample_t xh0, xh1;
  prod_t   p0, p1, p2;
  ff_t     ff;
  yval_t   y0, y1;
  yval_t   y1_next;
  fb_t     q2, q2_next;
  fb_t     m1;
  acc_t    acc;

  // a2 * y[n-2] is refreshed every cycle so it tracks the history and the
  // selected coefficient set; only a1 * y[n-1] sits in the feedback loop.
  assign y1_next = ctrl.fire ? y0 : y1;
  assign q2_next = coef.a2 * y1_next;
  assign m1      = coef.a1 * y0;

  assign acc = (ACC_W'(ff) <<< FRAC_BITS) + ACC_W'(m1) - ACC_W'(q2);

  always_ff @(posedge clk) begin
    if (rst) begin
      xh0 <= '0;
      xh1 <= '0;
      y0  <= '0;
      y1  <= '0;
      q2  <= '0;
    end else begin
      if (ctrl.load) begin
        xh1 <= xh0;
        xh0 <= x;
      end
      if (ctrl.fire) begin
        y1 <= y0;
        y0 <= y_round_sat(acc);
      end
      q2 <= q2_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      p0 <= coef.b0 * x;
      p1 <= coef.b1 * xh0;
      p2 <= coef.b2 * xh1;
    end
    if (ctrl.adv) begin
      ff <= FF_W'(p0) + FF_W'(p1) + FF_W'(p2);
    end
  end

  assign y = y0;

endmodule

// ===== rtl/sabq_merge.sv =====
// ---------------------------------------------------------------------------
// Lane merge and output register
// Rounds and saturates every lane result and packs them into one beat.
// ---------------------------------------------------------------------------
module sabq_merge (
  input  logic                clk,
  input  logic                rst,
  input  logic                lane_valid,
  output logic                lane_ready,
  input  sabq_pkg::yval_t     lane_y [sabq_pkg::LANES],
  output logic                result_valid,
  input  logic                result_ready,
  output sabq_pkg::sabq_out_t result
);
  import sabq_pkg::*;

  sample_t rounded [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      rounded[i] = out_round_sat(lane_y[i]);
    end
  end

  assign lane_ready = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (lane_ready) begin
      result_valid <= lane_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (lane_valid && lane_ready) begin
      result.gyro_x_filtered  <= rounded[0];
      result.gyro_y_filtered  <= rounded[1];
      result.gyro_z_filtered  <= rounded[2];
      result.accel_x_filtered <= rounded[AXES];
      result.accel_y_filtered <= rounded[AXES+1];
      result.accel_z_filtered <= rounded[AXES+2];
    end
  end

endmodule

// ===== rtl/six_axis_biquad_lowpass.sv =====
// ---------------------------------------------------------------------------
// Six-axis biquad low-pass filter
// Second-order Butterworth low-pass on three gyro and three accel axes.
// ---------------------------------------------------------------------------
// Usage:
//   A sample beat (sample_valid/sample_ready) carries one gyro and one accel
//   reading per axis. Each of the six axes runs its own biquad lane; a merge
//   stage rounds, saturates and packs them into one result beat
//   (result_valid/result_ready).
//   A beat passes the product, feedforward, history and merge registers;
//   one sample beat is taken per cycle unless the receiver stalls. The
//   feedback step (one multiply by a1 plus the Q22 sum, round and saturate)
//   is combinational. The pipeline holds up to four sample sets; if the
//   receiver stalls, sample_ready drops only once all stages are occupied.
//   Cutoffs are chosen through the APB port: register 0 (address 0) picks
//   the accel set, register 1 (address 4) the gyro set. Write them only
//   while no sample is in flight.
//   Reset clears the filter histories, the pipeline and selects 25 Hz accel,
//   100 Hz gyro.
// ---------------------------------------------------------------------------
`include "six_axis_biquad_lowpass_defines.svh"

module six_axis_biquad_lowpass (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sabq_pkg::ADDR_W-1:0]      paddr,
  input  logic [sabq_pkg::DATA_W-1:0]      pwdata,
  output logic [sabq_pkg::DATA_W-1:0]      prdata,
  output logic                             pready,
  input  logic                             sample_valid,
  output logic                             sample_ready,
  input  sabq_pkg::sabq_in_t               sample,
  output logic                             result_valid,
  input  logic                             result_ready,
  output sabq_pkg::sabq_out_t              result
);
  import sabq_pkg::*;

  logic [2:0] accel_sel;
  logic [1:0] gyro_sel;
  logic       reg_index;
  logic       cfg_write;

  coef_t      accel_set, gyro_set;

  logic       v1, v2, v3;
  logic       r1, r2, r3, r4;
  lane_ctrl_t lane_ctrl;
  sample_t    lane_x [LANES];
  yval_t      lane_y [LANES];

  // Configuration port
  assign pready    = 1'b1;
  assign reg_index = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_sel <= ACCEL_SEL_RESET;
      gyro_sel  <= GYRO_SEL_RESET;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_ACCEL_SEL: accel_sel <= pwdata[2:0];
        REG_GYRO_SEL:  gyro_sel  <= pwdata[1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_ACCEL_SEL: prdata = DATA_W'(accel_sel);
      REG_GYRO_SEL:  prdata = DATA_W'(gyro_sel);
      default:       prdata = '0;
    endcase
  end

  assign accel_set = accel_coef(accel_sel);
  assign gyro_set  = gyro_coef(gyro_sel);

  // Pipeline control: a stage takes a beat when it is empty or draining
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign sample_ready = r1;

  assign lane_ctrl.load = sample_valid && r1;
  assign lane_ctrl.adv  = v1 && r2;
  assign lane_ctrl.fire = v2 && r3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) begin
        v1 <= sample_valid;
      end
      if (r2) begin
        v2 <= v1;
      end
      if (r3) begin
        v3 <= v2;
      end
    end
  end

  assign lane_x[0]      = sample.gyro_x;
  assign lane_x[1]      = sample.gyro_y;
  assign lane_x[2]      = sample.gyro_z;
  assign lane_x[AXES]   = sample.accel_x;
  assign lane_x[AXES+1] = sample.accel_y;
  assign lane_x[AXES+2] = sample.accel_z;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    sabq_lane u_lane (
      .clk  (clk),
      .rst  (rst),
      .ctrl (lane_ctrl),
      .coef ((i < AXES) ? gyro_set : accel_set),
      .x    (lane_x[i]),
      .y    (lane_y[i])
    );
  end

  sabq_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .lane_valid   (v3),
    .lane_ready   (r4),
    .lane_y       (lane_y),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // Checks
  `SABQ_ASSERT_NEXT(a_fire_lands, clk, rst, lane_ctrl.fire, v3, "feedback step lost its result")
  `SABQ_ASSERT_NEXT(a_hold_history, clk, rst, v3 && !r4, v3 && $stable(lane_y[0]), "stalled result overwritten")
  `SABQ_ASSERT_NOW(a_empty_ready, clk, rst, !v1 && !v2 && !v3, sample_ready, "empty pipeline refused a beat")

endmodule

// ===== dv/six_axis_biquad_lowpass_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Six-axis biquad low-pass: block-level testbench
// Streams gyro/accel sample sets through the filter under several cutoff
// settings and random handshake gaps. A bit-exact fixed-point model of the
// six biquad lanes predicts every result beat, which is checked per field.
// ---------------------------------------------------------------------------

class biquad_scoreboard;

  typedef struct {
    int b0;
    int b1;
    int b2;
    int a1;
    int a2;
  } taps_t;

  bit [2:0]             accel_sel;
  bit [1:0]             gyro_sel;
  longint               x_hist[sabq_pkg::LANES][2];
  longint               y_hist[sabq_pkg::LANES][2];
  sabq_pkg::sabq_out_t  expected_filtered[$];
  int unsigned          failures;

  function new();
    accel_sel = sabq_pkg::ACCEL_SEL_RESET;
    gyro_sel  = sabq_pkg::GYRO_SEL_RESET;
    foreach (x_hist[i, j]) begin
      x_hist[i][j] = 0;
      y_hist[i][j] = 0;
    end
    failures = 0;
  endfunction

  function void report(string what, longint want, longint got);
    failures++;
    $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
  endfunction

  function void write_register(logic idx, logic [sabq_pkg::DATA_W-1:0] value);
    // drop bits above the register width
    if (idx == sabq_pkg::REG_ACCEL_SEL) accel_sel = value[2:0];
    else gyro_sel = value[1:0];
  endfunction

  function logic [sabq_pkg::DATA_W-1:0] register_value(logic idx);
    if (idx == sabq_pkg::REG_ACCEL_SEL) return sabq_pkg::DATA_W'(accel_sel);
    return sabq_pkg::DATA_W'(gyro_sel);
  endfunction

  // Unused selector codes fall back to the slowest set of each sensor.
  function taps_t pick_taps(bit is_accel);
    taps_t t;
    if (is_accel) begin
      case (accel_sel)
        sabq_pkg::ACCEL_50HZ: t = '{1478, 2956, 1478, 16211, 5739};
        sabq_pkg::ACCEL_25HZ: t = '{480, 960, 480, 23936, 9471};
        sabq_pkg::ACCEL_15HZ: t = '{193, 385, 193, 27373, 11759};
        sabq_pkg::ACCEL_10HZ: t = '{90, 181, 90, 29148, 13126};
        default:              t = '{24, 48, 24, 30951, 14663};
      endcase
    end else begin
      case (gyro_sel)
        sabq_pkg::GYRO_100HZ: t = '{3705, 7411, 3705, 4603, 3040};
        sabq_pkg::GYRO_50HZ:  t = '{1478, 2956, 1478, 16211, 5739};
        default:              t = '{480, 960, 480, 23936, 9471};
      endcase
    end
    return t;
  endfunction

  function longint clamp(longint v, int bits);
    longint hi;
    hi = (longint'(1) << (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // One direct-form-I step: Q22 sum, round to Q8 state, round to integer.
  function longint filter_lane(taps_t t, int lane, longint x);
    longint acc;
    longint y;
    acc = (t.b0 * x + t.b1 * x_hist[lane][0] + t.b2 * x_hist[lane][1])
          * (longint'(1) << sabq_pkg::FRAC_BITS)
          + t.a1 * y_hist[lane][0] - t.a2 * y_hist[lane][1];
    y = clamp((acc + (longint'(1) << (sabq_pkg::COEF_FRAC - 1))) >>> sabq_pkg::COEF_FRAC,
              sabq_pkg::Y_W);
    x_hist[lane][1] = x_hist[lane][0];
    x_hist[lane][0] = x;
    y_hist[lane][1] = y_hist[lane][0];
    y_hist[lane][0] = y;
    return clamp((y + (longint'(1) << (sabq_pkg::FRAC_BITS - 1))) >>> sabq_pkg::FRAC_BITS,
                 sabq_pkg::SAMPLE_BITS);
  endfunction

  function void note_sample(sabq_pkg::sabq_in_t s);
    sabq_pkg::sample_t   xs[sabq_pkg::LANES];
    sabq_pkg::sample_t   ys[sabq_pkg::LANES];
    sabq_pkg::sabq_out_t e;
    taps_t               gt;
    taps_t               at;
    gt = pick_taps(1'b0);
    at = pick_taps(1'b1);
    xs = '{s.gyro_x, s.gyro_y, s.gyro_z, s.accel_x, s.accel_y, s.accel_z};
    foreach (xs[i]) begin
      ys[i] = sabq_pkg::sample_t'(filter_lane(i < sabq_pkg::AXES ? gt : at, i,
                                              longint'(xs[i])));
    end
    e = {ys[0], ys[1], ys[2], ys[3], ys[4], ys[5]};
    expected_filtered.push_back(e);
  endfunction

  function void check_result(sabq_pkg::sabq_out_t r);
    sabq_pkg::sabq_out_t e;
    sabq_pkg::sample_t   want[sabq_pkg::LANES];
    sabq_pkg::sample_t   got[sabq_pkg::LANES];
    string               names[sabq_pkg::LANES];
    names = '{"gyro_x_filtered", "gyro_y_filtered", "gyro_z_filtered",
              "accel_x_filtered", "accel_y_filtered", "accel_z_filtered"};
    if (expected_filtered.size() == 0) begin
      report("unexpected result beat, gyro_x_filtered", 0, r.gyro_x_filtered);
      return;
    end
    e = expected_filtered.pop_front();
    want = '{e.gyro_x_filtered, e.gyro_y_filtered, e.gyro_z_filtered,
             e.accel_x_filtered, e.accel_y_filtered, e.accel_z_filtered};
    got  = '{r.gyro_x_filtered, r.gyro_y_filtered, r.gyro_z_filtered,
             r.accel_x_filtered, r.accel_y_filtered, r.accel_z_filtered};
    foreach (want[i]) begin
      if (got[i] !== want[i]) report(names[i], want[i], got[i]);
    end
  endfunction

  function int pending();
    return expected_filtered.size();
  endfunction

endclass

module six_axis_biquad_lowpass_test;
  import sabq_pkg::*;

  localparam int PHASES          = 9;
  localparam int DIRECTED_ITEMS  = 22;
  localparam int ITEMS_PER_PHASE = 45;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int DRAIN_CYCLES    = 8;
  localparam int STALL_LIMIT     = 2000;

  // Selector codes without a name in the package; 5 to 7 and 3 are aliases.
  localparam logic [2:0] ACCEL_5HZ     = 3'd4;
  localparam logic [2:0] ACCEL_ALIAS_A = 3'd5;
  localparam logic [2:0] ACCEL_ALIAS_B = 3'd6;
  localparam logic [2:0] ACCEL_ALIAS_C = 3'd7;
  localparam logic [1:0] GYRO_25HZ     = 2'd2;
  localparam logic [1:0] GYRO_ALIAS    = 2'd3;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              sample_valid;
  logic              sample_ready;
  sabq_in_t          sample;
  logic              result_valid;
  logic              result_ready;
  sabq_out_t         result;

  biquad_scoreboard  filter_check = new();
  int unsigned       send_idle_pct;
  int unsigned       recv_idle_pct;
  bit                hold_off_request;
  int unsigned       stalled_cycles;

  six_axis_biquad_lowpass dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && sample_valid && sample_ready) filter_check.note_sample(sample);
    if (!rst && result_valid && result_ready) filter_check.check_result(result);
  end

  always @(posedge clk) begin
    if (rst || psel || (sample_valid && sample_ready) || (result_valid && result_ready)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= STALL_LIMIT) begin
        $display("six_axis_biquad_lowpass: mismatch");
        $finish;
      end
    end
  end

  // Result side: random backpressure, plus one long hold-off on request.
  initial begin
    result_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_request) begin
        result_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_request = 1'b0;
      end else begin
        result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic push_sample(input sabq_in_t s);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct && gap < 40) gap++;
    if (gap != 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample       <= s;
    sample_valid <= 1'b1;
    do @(posedge clk); while (!sample_ready);
  endtask

  task automatic apb_access(input logic idx, input logic wr, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (wr) begin
      filter_check.write_register(idx, value);
    end else if (prdata !== filter_check.register_value(idx)) begin
      filter_check.report(idx == REG_ACCEL_SEL ? "accel_cutoff_select read"
                                               : "gyro_cutoff_select read",
                          filter_check.register_value(idx), prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // idle between accesses
    @(posedge clk);
  endtask

  // Upper data bits are random so the dropped bits toggle too.
  task automatic set_cutoffs(input logic [2:0] accel, input logic [1:0] gyro);
    apb_access(REG_ACCEL_SEL, 1'b1, {29'($urandom_range(0, 32'h1fff_ffff)), accel});
    apb_access(REG_GYRO_SEL, 1'b1, {30'($urandom_range(0, 32'h3fff_ffff)), gyro});
    apb_access(REG_ACCEL_SEL, 1'b0, '0);
    apb_access(REG_GYRO_SEL, 1'b0, '0);
  endtask

  task automatic drain();
    while (filter_check.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Steps between the rails make the filters overshoot into saturation.
  function automatic sabq_in_t directed_sample(int k);
    sample_t top;
    sample_t bot;
    top = 16'sh7fff;
    bot = 16'sh8000;
    if (k == 0) return '0;
    if (k <= 5) return {6{top}};
    if (k <= 10) return {6{bot}};
    if (k <= 16) return (k % 2) ? {6{top}} : {6{bot}};
    if (k == 17) return {top, top, top, bot, bot, bot};
    if (k == 18) return {bot, bot, bot, top, top, top};
    if (k == 19) return {16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa};
    if (k == 20) return {6{16'shffff}};
    return {6{16'sh0001}};
  endfunction

  function automatic sabq_in_t random_sample();
    sample_t f[LANES];
    int      kind;
    kind = $urandom_range(0, 9);
    foreach (f[i]) begin
      if (kind < 4) begin
        f[i] = sample_t'($urandom());
      end else if (kind < 6) begin
        case ($urandom_range(0, 3))
          0:       f[i] = 16'sh7fff;
          1:       f[i] = 16'sh8000;
          2:       f[i] = '0;
          default: f[i] = 16'shffff;
        endcase
      end else begin
        f[i] = sample_t'(int'($urandom_range(0, 400)) - 200);
      end
    end
    return {f[0], f[1], f[2], f[3], f[4], f[5]};
  endfunction

  initial begin : stimulus
    logic [2:0] accel_plan[PHASES];
    logic [1:0] gyro_plan[PHASES];
    sabq_in_t   cur;
    int         run_left;
    accel_plan = '{ACCEL_SEL_RESET, ACCEL_50HZ, ACCEL_5HZ, ACCEL_ALIAS_C, ACCEL_15HZ,
                   ACCEL_10HZ, ACCEL_ALIAS_A, ACCEL_ALIAS_B, ACCEL_5HZ};
    gyro_plan  = '{GYRO_SEL_RESET, GYRO_100HZ, GYRO_25HZ, GYRO_ALIAS, GYRO_50HZ,
                   GYRO_25HZ, GYRO_100HZ, GYRO_ALIAS, GYRO_50HZ};
    rst              <= 1'b1;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    sample_valid     <= 1'b0;
    sample           <= '0;
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    hold_off_request = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values first, then the rail and pattern beats.
    apb_access(REG_ACCEL_SEL, 1'b0, '0);
    apb_access(REG_GYRO_SEL, 1'b0, '0);
    send_idle_pct = 9;
    recv_idle_pct = 86;
    for (int k = 0; k < DIRECTED_ITEMS; k++) push_sample(directed_sample(k));
    sample_valid <= 1'b0;
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase / 3)
        0: begin
          send_idle_pct = 9;
          recv_idle_pct = 86;
        end
        1: begin
          send_idle_pct = 86;
          recv_idle_pct = 9;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (phase != 0) set_cutoffs(accel_plan[phase], gyro_plan[phase]);
      // Stall the result side long enough to fill the pipeline.
      if (phase == 6) hold_off_request = 1'b1;
      run_left = 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Hold a sample for a run now and then: steps settle and overshoot.
        if (run_left == 0) begin
          cur      = random_sample();
          run_left = ($urandom_range(0, 2) == 0) ? $urandom_range(4, 24) : 1;
        end
        push_sample(cur);
        run_left--;
      end
      sample_valid <= 1'b0;
      drain();
    end

    if (filter_check.failures == 0 && filter_check.pending() == 0) begin
      $display("six_axis_biquad_lowpass: match");
    end else begin
      $display("six_axis_biquad_lowpass: mismatch");
    end
    $finish;
  end

endmodule
